// File: rtl/fir_rvb_pkg.sv
// ----------------------------------------------------------------------------
// fir_rvb_pkg
// Shared constants, types and state codes of the reverb FIR filter.
// ----------------------------------------------------------------------------
package fir_rvb_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;

    // fixed field widths of the ports
    localparam int IDX_W = 10;
    localparam int CFG_W = 11;

    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int Y_W    = ACC_W - FRAC_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_COEF   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                          is_sample;
        logic                          idx_ok;
        logic [IDX_W-1:0]              index;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND
    } t_back_state;

endpackage

// File: rtl/fir_rvb_intf.sv
// ----------------------------------------------------------------------------
// fir_rvb_intf
// Valid/ready channels of the reverb FIR filter: samples in, results out,
// and the tap count write port.
// ----------------------------------------------------------------------------
interface fir_rvb_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     opcode;
    logic [fir_rvb_pkg::IDX_W-1:0]            coef_index;
    logic signed [fir_rvb_pkg::SAMPLE_BITS-1:0] value;

    modport source (output valid, output opcode, output coef_index, output value,
                    input ready);
    modport sink   (input valid, input opcode, input coef_index, input value,
                    output ready);
endinterface

interface fir_rvb_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [fir_rvb_pkg::SAMPLE_BITS-1:0] output_sample;
    logic                                     saturated;

    modport source (output valid, output output_sample, output saturated,
                    input ready);
    modport sink   (input valid, input output_sample, input saturated,
                    output ready);
endinterface

interface fir_rvb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fir_rvb_pkg::CFG_W-1:0] tap_count;

    modport source (output valid, output tap_count, input ready);
    modport sink   (input valid, input tap_count, output ready);
endinterface

// File: rtl/fir_reverb_filter.sv
// ----------------------------------------------------------------------------
// fir_reverb_filter
// Long direct-form FIR filter for reverb, Q1.15 in and out.
// ----------------------------------------------------------------------------
// After reset the block clears the coefficient store and takes no input
// transactions during that time. A transaction with opcode 0 writes one
// coefficient; opcode 1 feeds a sample and returns one rounded, saturated
// result, computed by the single multiply-accumulate that walks all taps
// through one read port of each memory. A two-entry command queue sits
// between the input side and the back end, and the result waits in an output
// register. Writing tap_count clears the delay line and restarts its write
// position; coefficients are kept.
// ----------------------------------------------------------------------------
module fir_reverb_filter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fir_rvb_cfg_if.sink    i_cfg,
    fir_rvb_in_if.sink     i_in,
    fir_rvb_out_if.source  o_out
);

    fir_rvb_pkg::t_queue_head  head;
    fir_rvb_pkg::t_back_status status;

    fir_rvb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (status),
        .o_head   (head)
    );

    fir_rvb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_head   (head),
        .o_status (status)
    );

endmodule

// File: rtl/fir_rvb_ram.sv
// ----------------------------------------------------------------------------
// fir_rvb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fir_rvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fir_rvb_front.sv
// ----------------------------------------------------------------------------
// fir_rvb_front
// Takes input transactions, classifies them into commands and holds them in
// a short queue for the back end.
// ----------------------------------------------------------------------------
module fir_rvb_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fir_rvb_in_if.sink                i_in,
    input  fir_rvb_pkg::t_back_status i_status,
    output fir_rvb_pkg::t_queue_head  o_head
);

    fir_rvb_pkg::t_cmd               r_queue [fir_rvb_pkg::QUEUE_DEPTH];
    logic [fir_rvb_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [fir_rvb_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [fir_rvb_pkg::QCNT_W-1:0]  r_count;
    fir_rvb_pkg::t_cmd               cmd_in;
    logic                            push;
    logic                            pop;

    always_comb begin
        cmd_in.is_sample = (fir_rvb_pkg::t_opcode'(i_in.opcode) == fir_rvb_pkg::OP_SAMPLE);
        cmd_in.idx_ok    = ({1'b0, i_in.coef_index} <
                            (fir_rvb_pkg::IDX_W + 1)'(fir_rvb_pkg::MAX_TAPS));
        cmd_in.index     = i_in.coef_index;
        cmd_in.value     = i_in.value;
    end

    // no transactions while the coefficient store is being cleared
    assign i_in.ready = (r_count != fir_rvb_pkg::QCNT_W'(fir_rvb_pkg::QUEUE_DEPTH))
                        && !i_status.clearing;
    assign push = i_in.valid && i_in.ready;
    assign pop  = i_status.pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

endmodule

// File: rtl/fir_rvb_back.sv
// ----------------------------------------------------------------------------
// fir_rvb_back
// Executes queued commands: coefficient writes, and per sample a delay line
// write followed by a serial multiply-accumulate, rounding and saturation.
// ----------------------------------------------------------------------------
module fir_rvb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fir_rvb_cfg_if.sink               i_cfg,
    fir_rvb_out_if.source             o_out,
    input  fir_rvb_pkg::t_queue_head  i_head,
    output fir_rvb_pkg::t_back_status o_status
);

    localparam int SB = fir_rvb_pkg::SAMPLE_BITS;
    localparam int TW = fir_rvb_pkg::TAP_W;
    localparam int CW = fir_rvb_pkg::CNT_W;
    localparam int AW = fir_rvb_pkg::ACC_W;
    localparam int YW = fir_rvb_pkg::Y_W;
    localparam int FB = fir_rvb_pkg::FRAC_BITS;

    fir_rvb_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]                  r_tap_count;
    logic [CW-1:0]                  r_fill;
    logic [TW-1:0]                  r_wp;
    logic [TW-1:0]                  r_clr_addr;
    logic [TW-1:0]                  r_m;
    logic [TW-1:0]                  r_pos;
    logic                           r_v1, r_v2, r_last1, r_last2, r_zero1;
    logic signed [fir_rvb_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0]           r_acc;
    logic                           r_out_valid;
    logic signed [SB-1:0]           r_out_sample;
    logic                           r_out_sat;

    logic                           pop, issue, out_load, coef_we, delay_we;
    logic [TW-1:0]                  coef_waddr;
    logic [SB-1:0]                  coef_wdata;
    logic [SB-1:0]                  coef_rdata, delay_rdata;
    logic [TW-1:0]                  last_m;
    logic [CW-1:0]                  wp_inc;
    logic [CW-1:0]                  cfg_taps;
    logic signed [SB-1:0]           mul_b;
    logic signed [AW-1:0]           acc_rnd;
    logic signed [YW-1:0]           y, y_max, y_min;
    logic                           sat_hi, sat_lo;
    logic signed [SB-1:0]           y_out;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fir_rvb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign last_m = TW'(r_tap_count - 1'b1);

    always_comb begin
        n_state    = r_state;
        pop        = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        coef_we    = 1'b0;
        delay_we   = 1'b0;
        coef_waddr = r_clr_addr;
        coef_wdata = '0;
        unique case (r_state)
            fir_rvb_pkg::S_CLEAR: begin
                coef_we = 1'b1;
                if (r_clr_addr == TW'(fir_rvb_pkg::MAX_TAPS - 1)) begin
                    n_state = fir_rvb_pkg::S_IDLE;
                end
            end
            fir_rvb_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    pop = 1'b1;
                    if (i_head.cmd.is_sample) begin
                        delay_we = 1'b1;
                        n_state  = fir_rvb_pkg::S_MAC;
                    end else begin
                        coef_we    = i_head.cmd.idx_ok;
                        coef_waddr = TW'(i_head.cmd.index);
                        coef_wdata = i_head.cmd.value;
                    end
                end
            end
            fir_rvb_pkg::S_MAC: begin
                issue = 1'b1;
                if (r_m == last_m) begin
                    n_state = fir_rvb_pkg::S_DRAIN;
                end
            end
            fir_rvb_pkg::S_DRAIN: begin
                if (r_last2) begin
                    n_state = fir_rvb_pkg::S_ROUND;
                end
            end
            fir_rvb_pkg::S_ROUND: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = fir_rvb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fir_rvb_pkg::S_IDLE;
            end
        endcase
    end

    assign o_status.pop      = pop;
    assign o_status.clearing = (r_state == fir_rvb_pkg::S_CLEAR);

    // ---------------- memories ----------------
    fir_rvb_ram #(.WIDTH(SB), .DEPTH(fir_rvb_pkg::MAX_TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_m),
        .o_rdata (coef_rdata)
    );

    fir_rvb_ram #(.WIDTH(SB), .DEPTH(fir_rvb_pkg::MAX_TAPS)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (delay_we),
        .i_waddr (r_wp),
        .i_wdata (i_head.cmd.value),
        .i_raddr (r_pos),
        .o_rdata (delay_rdata)
    );

    // ---------------- configuration and position ----------------
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.tap_count == '0) begin
            cfg_taps = CW'(1);
        end else if ({1'b0, i_cfg.tap_count} > (fir_rvb_pkg::CFG_W + 1)'(fir_rvb_pkg::MAX_TAPS)) begin
            cfg_taps = CW'(fir_rvb_pkg::MAX_TAPS);
        end else begin
            cfg_taps = CW'(i_cfg.tap_count);
        end
    end

    assign wp_inc = CW'(r_wp) + 1'b1;

    // r_fill counts positions written since the last clear; positions at or
    // beyond that count read as zero, so the delay line needs no clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= CW'(fir_rvb_pkg::MAX_TAPS);
            r_fill      <= '0;
            r_wp        <= '0;
            r_clr_addr  <= '0;
        end else begin
            if (r_state == fir_rvb_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_tap_count <= cfg_taps;
                r_fill      <= '0;
                r_wp        <= '0;
            end else if (delay_we) begin
                r_wp <= (wp_inc >= r_tap_count) ? '0 : wp_inc[TW-1:0];
                if (r_fill < r_tap_count) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // ---------------- multiply-accumulate pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_last1 <= 1'b0;
            r_last2 <= 1'b0;
        end else begin
            r_v1    <= issue;
            r_last1 <= issue && (r_m == last_m);
            r_v2    <= r_v1;
            r_last2 <= r_last1;
        end
    end

    assign mul_b = r_zero1 ? '0 : $signed(delay_rdata);

    always_ff @(posedge i_clk) begin
        if (delay_we) begin
            r_m   <= '0;
            r_pos <= r_wp;
            r_acc <= '0;
        end else begin
            if (issue) begin
                r_m   <= r_m + 1'b1;
                r_pos <= (r_pos == '0) ? last_m : r_pos - 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
        r_zero1 <= (CW'(r_pos) >= r_fill);
        r_prod  <= $signed(coef_rdata) * mul_b;
    end

    // ---------------- round, saturate, output register ----------------
    assign acc_rnd = r_acc + AW'(1 << (FB - 1));
    assign y       = $signed(acc_rnd[AW-1:FB]);
    assign y_max   = YW'((1 << FB) - 1);
    assign y_min   = ~y_max;
    assign sat_hi  = (y > y_max);
    assign sat_lo  = (y < y_min);

    always_comb begin
        if (sat_hi) begin
            y_out = SB'(y_max);
        end else if (sat_lo) begin
            y_out = SB'(y_min);
        end else begin
            y_out = y[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= y_out;
            r_out_sat    <= sat_hi || sat_lo;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.output_sample = r_out_sample;
    assign o_out.saturated     = r_out_sat;

    // ---------------- assertions ----------------
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_tap_count)
        else $error("fill count beyond tap count");

    a_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_wp) < r_tap_count)
        else $error("write position beyond tap count");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last2 |-> (r_state == fir_rvb_pkg::S_DRAIN))
        else $error("last product outside drain");

    a_round_empty_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_rvb_pkg::S_ROUND) |-> (!r_v1 && !r_v2))
        else $error("products still in flight at rounding");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_rvb_pkg::S_CLEAR) |=> !$past(pop))
        else $error("command taken while clearing");

endmodule
